// ----- hdl/mwse_pkg.sv -----
// mwse_pkg: shared types, constants and state encodings for the
// mask-weighted squared error block; no dependencies
`timescale 1ns / 1ps

package mwse_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int SIZE_CFG_W = 7;
  localparam int FRAME_W    = 16;
  localparam int COORD_W    = 16;
  localparam int WORD_W     = 16;
  localparam int MADDR_W    = 12;
  localparam int COST_W     = 48;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // signed numerator and unsigned denominator of the scaled index
  localparam int NUM_W = COORD_W + 3;
  localparam int DEN_W = COORD_W + 1;

  localparam int MUL_A_W = 2 * WORD_W;
  localparam int MUL_B_W = WORD_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [COST_W-1:0]     COST_MAX        = '1;
  localparam logic [SIZE_CFG_W-1:0] MASK_ROWS_RST   = SIZE_CFG_W'(64);
  localparam logic [SIZE_CFG_W-1:0] MASK_COLS_RST   = SIZE_CFG_W'(64);
  localparam logic [FRAME_W-1:0]    FIRST_FRAME_RST = FRAME_W'(1);
  localparam logic [FRAME_W-1:0]    FINAL_FRAME_RST = FRAME_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK_ROWS,
    CFG_MASK_COLS,
    CFG_FIRST_FRAME,
    CFG_FINAL_FRAME
  } cfg_reg_t;

  typedef struct packed {
    logic               action;
    logic [MADDR_W-1:0] mask_address;
    logic [WORD_W-1:0]  value;
    logic               inside_req;
    logic [FRAME_W-1:0] frame;
    logic [COORD_W-1:0] centroid_row;
    logic [COORD_W-1:0] centroid_col;
    logic [COORD_W-1:0] box_center_x;
    logic [COORD_W-1:0] box_bottom_y;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0]  total_cost;
    logic [COUNT_W-1:0] matched_count;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_START,
    ST_COL_WAIT,
    ST_ROW_START,
    ST_ROW_WAIT,
    ST_ADDR,
    ST_READ,
    ST_DIFF,
    ST_MUL_DD,
    ST_MUL_W,
    ST_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_SCALE,
    DV_CHECK,
    DV_RANGE,
    DV_STEP,
    DV_DONE
  } div_state_t;

endpackage

// ----- hdl/mwse_ram.sv -----
// mwse_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
`timescale 1ns / 1ps

module mwse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/mwse_div.sv -----
// mwse_div: bit-serial scaled index unit, round(n*num/den) clamped to [1, n]
// minus one, one quotient bit per cycle; depends on mwse_pkg
`timescale 1ns / 1ps

module mwse_div import mwse_pkg::*; #(
  parameter int SIZE_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  input  logic [SIZE_W-1:0]       size,
  output logic [SIZE_W-1:0]       idx,
  output unit_stat_t              stat
);

  localparam int PW    = NUM_W - 1 + SIZE_W;
  localparam int DW    = PW + 2;
  localparam int VW    = DEN_W + 1;
  localparam int QW    = SIZE_W;
  localparam int CW    = (DW > VW + QW) ? DW : VW + QW;
  localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

  div_state_t state, state_next;

  logic [NUM_W-2:0]  mag;
  logic [DEN_W-1:0]  den_r;
  logic [SIZE_W-1:0] size_r;
  logic [PW-1:0]     prod;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     vshift;
  logic [QW-1:0]     q;
  logic [CNT_W-1:0]  cnt;
  logic              nonpos;
  logic              over;
  logic              fits;
  logic [SIZE_W-1:0] q_clamp;

  assign nonpos = num[NUM_W-1] || (num == '0);
  assign over   = rem >= (vshift << 1);
  assign fits   = rem >= vshift;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          state_next = (nonpos || den == '0) ? DV_DONE : DV_SCALE;
        end
      end
      DV_SCALE: state_next = DV_CHECK;
      DV_CHECK: state_next = DV_RANGE;
      DV_RANGE: state_next = over ? DV_DONE : DV_STEP;
      DV_STEP: begin
        if (cnt == '0) begin
          state_next = DV_DONE;
        end
      end
      DV_DONE: state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          mag    <= num[NUM_W-2:0];
          den_r  <= den;
          size_r <= size;
          q      <= nonpos ? '0 : QW'(size);
        end
      end
      DV_SCALE: prod <= PW'(mag) * PW'(size_r);
      DV_CHECK: begin
        rem    <= CW'({prod, 1'b0}) + CW'(den_r);
        vshift <= CW'({den_r, 1'b0}) << (QW - 1);
      end
      DV_RANGE: begin
        if (over) begin
          q <= QW'(size_r);
        end
        cnt <= CNT_W'(QW - 1);
      end
      DV_STEP: begin
        if (fits) begin
          rem <= rem - vshift;
        end
        q      <= QW'({q, fits});
        vshift <= vshift >> 1;
        cnt    <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // clamp to [1, size], then make it zero based
  always_comb begin
    if (q == '0) begin
      q_clamp = SIZE_W'(1);
    end else if (q > QW'(size_r)) begin
      q_clamp = size_r;
    end else begin
      q_clamp = SIZE_W'(q);
    end
    idx = q_clamp - 1'b1;
  end

  assign stat.busy = (state != DV_IDLE);
  assign stat.done = (state == DV_DONE);

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    stat.done && size_r != '0 |-> idx < size_r)
    else $error("scaled index beyond mask size");
`endif

endmodule

// ----- hdl/mwse_mul.sv -----
// mwse_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on mwse_pkg for the status struct and the default widths
`timescale 1ns / 1ps

module mwse_mul import mwse_pkg::*; #(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] product,
  output unit_stat_t       stat
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [A_W-1:0]   a_reg;
  logic [P_W-1:0]   p;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [A_W:0]     sum;

  assign sum = {1'b0, p[P_W-1:B_W]} + ((p[0]) ? {1'b0, a_reg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_reg <= a;
      p     <= {{A_W{1'b0}}, b};
    end else if (busy) begin
      p <= P_W'({sum, p[B_W-1:0]} >> 1);
    end
  end

  assign product   = p;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- hdl/mask_weighted_squared_error.sv -----
// mask_weighted_squared_error: mask store, superpixel scaling and cost accumulation.
// Mask writes and superpixels that do not count are taken back to back.
// A counting superpixel holds the block for two bit-serial divider runs (column, then
// row), a mask read, then two bit-serial multiplies (d*d, then w*d*d).
// After the last superpixel the result is registered onto out_valid once any earlier result is taken.
// Reset clears control, accumulators and config; the mask store keeps its contents.
`timescale 1ns / 1ps

module mask_weighted_squared_error import mwse_pkg::*; #(
  parameter int MAX_MASK_ROWS = MAX_ROWS_DEF,
  parameter int MAX_MASK_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH    = MAX_MASK_ROWS * MAX_MASK_COLS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAX_SIZE = (MAX_MASK_ROWS > MAX_MASK_COLS) ? MAX_MASK_ROWS : MAX_MASK_COLS;
  localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
  localparam int IDX2_W   = 2 * SIZE_W;

  top_state_t state, state_next;

  logic [SIZE_CFG_W-1:0] mask_rows;
  logic [SIZE_CFG_W-1:0] mask_cols;
  logic [FRAME_W-1:0]    first_frame;
  logic [FRAME_W-1:0]    final_frame;

  logic signed [NUM_W-1:0] num_col;
  logic signed [NUM_W-1:0] num_row;
  logic [DEN_W-1:0]        den_col;
  logic [DEN_W-1:0]        den_row;
  logic [WORD_W-1:0]       target;
  logic                    last_item;
  logic [SIZE_W-1:0]       col_idx;
  logic [SIZE_W-1:0]       row_idx;
  logic [ADDR_W-1:0]       rd_addr;
  logic [WORD_W-1:0]       weight;
  logic [COST_W-1:0]       cost_acc;
  logic [COUNT_W-1:0]      match_cnt;
  logic                    sat_flag;

  logic [SIZE_W-1:0]       rows_eff;
  logic [SIZE_W-1:0]       cols_eff;
  logic                    in_accept;
  logic                    match;
  logic                    ram_wr_en;
  logic                    ram_rd_en;
  logic [WORD_W-1:0]       rd_data;
  logic [WORD_W-1:0]       diff;
  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic [SIZE_W-1:0]       div_size;
  logic [SIZE_W-1:0]       div_idx;
  unit_stat_t              div_stat;
  logic                    mul_start;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       mul_prod;
  unit_stat_t              mul_stat;
  logic                    accum;
  logic                    emit;
  logic [COST_W:0]         cost_sum;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_rows   <= MASK_ROWS_RST;
      mask_cols   <= MASK_COLS_RST;
      first_frame <= FIRST_FRAME_RST;
      final_frame <= FINAL_FRAME_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_MASK_ROWS:   mask_rows   <= cfg_data[SIZE_CFG_W-1:0];
        CFG_MASK_COLS:   mask_cols   <= cfg_data[SIZE_CFG_W-1:0];
        CFG_FIRST_FRAME: first_frame <= cfg_data[FRAME_W-1:0];
        CFG_FINAL_FRAME: final_frame <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // mask sizes saturated to [1, max]
  always_comb begin
    if (mask_rows == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (32'(mask_rows) > 32'(MAX_MASK_ROWS)) begin
      rows_eff = SIZE_W'(MAX_MASK_ROWS);
    end else begin
      rows_eff = SIZE_W'(mask_rows);
    end
    if (mask_cols == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (32'(mask_cols) > 32'(MAX_MASK_COLS)) begin
      cols_eff = SIZE_W'(MAX_MASK_COLS);
    end else begin
      cols_eff = SIZE_W'(mask_cols);
    end
  end

  assign in_accept = in_valid && in_ready;
  assign match     = in_data.inside_req && (in_data.frame >= first_frame)
                     && (in_data.frame <= final_frame);
  assign ram_wr_en = in_accept && !in_data.action
                     && (32'(in_data.mask_address) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    ram_rd_en  = 1'b0;
    accum      = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.action) begin
          if (match) begin
            state_next = ST_COL_START;
          end else if (in_data.last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_COL_START: begin
        div_start  = 1'b1;
        state_next = ST_COL_WAIT;
      end
      ST_COL_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        div_start  = 1'b1;
        state_next = ST_ROW_WAIT;
      end
      ST_ROW_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: begin
        ram_rd_en  = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_DD;
      end
      ST_MUL_DD: begin
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL_W;
        end
      end
      ST_MUL_W: begin
        if (mul_stat.done) begin
          accum      = 1'b1;
          state_next = last_item ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // item capture, scaled-index operands
  always_ff @(posedge clk) begin
    if (in_accept) begin
      num_col   <= NUM_W'({in_data.centroid_col, 1'b0}) - NUM_W'({in_data.box_center_x, 1'b0})
                   + NUM_W'(in_data.box_width);
      den_col   <= {in_data.box_width, 1'b0};
      num_row   <= NUM_W'(in_data.centroid_row) - NUM_W'(in_data.box_bottom_y)
                   + NUM_W'(in_data.box_height);
      den_row   <= DEN_W'(in_data.box_height);
      target    <= in_data.value;
      last_item <= in_data.last;
    end
    if (state == ST_COL_WAIT && div_stat.done) begin
      col_idx <= div_idx;
    end
    if (state == ST_ROW_WAIT && div_stat.done) begin
      row_idx <= div_idx;
    end
    if (state == ST_ADDR) begin
      rd_addr <= ADDR_W'(IDX2_W'(row_idx) + IDX2_W'(col_idx) * IDX2_W'(rows_eff));
    end
    if (state == ST_DIFF) begin
      weight <= rd_data;
    end
  end

  assign div_num  = (state == ST_COL_START) ? num_col : num_row;
  assign div_den  = (state == ST_COL_START) ? den_col : den_row;
  assign div_size = (state == ST_COL_START) ? cols_eff : rows_eff;

  assign diff  = (rd_data >= target) ? rd_data - target : target - rd_data;
  assign mul_a = (state == ST_DIFF) ? MUL_A_W'(diff) : mul_prod[MUL_A_W-1:0];
  assign mul_b = (state == ST_DIFF) ? diff : weight;

  // term is w*d*d with w in Q0.16, truncated to an integer in Q32.0
  assign cost_sum = {1'b0, cost_acc} + (COST_W + 1)'(mul_prod[PROD_W-1:WORD_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_acc  <= '0;
      match_cnt <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        cost_acc  <= '0;
        match_cnt <= '0;
        sat_flag  <= 1'b0;
      end else if (accum) begin
        if (match_cnt != '1) begin
          match_cnt <= match_cnt + 1'b1;
        end
        if (cost_sum[COST_W]) begin
          cost_acc <= COST_MAX;
          sat_flag <= 1'b1;
        end else begin
          cost_acc <= cost_sum[COST_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= '{total_cost: cost_acc, matched_count: match_cnt, saturated: sat_flag};
    end
  end

  mwse_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ADDR_W'(in_data.mask_address)),
    .wr_data (in_data.value),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mwse_div #(
    .SIZE_W (SIZE_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .size  (div_size),
    .idx   (div_idx),
    .stat  (div_stat)
  );

  mwse_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod),
    .stat    (mul_stat)
  );

`ifndef SYNTHESIS
  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_COL_WAIT || state == ST_ROW_WAIT))
    else $error("divider running outside its wait states");

  a_mul_busy_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_stat.busy |-> (state == ST_MUL_DD || state == ST_MUL_W))
    else $error("multiplier running outside its states");

  a_sat_pins_max: assert property (@(posedge clk) disable iff (rst)
    sat_flag |-> cost_acc == COST_MAX)
    else $error("saturation flag set without a saturated total");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> (cost_acc == '0 && match_cnt == '0 && !sat_flag))
    else $error("accumulators not cleared after a result transaction");
`endif

endmodule
